// File: rtl/core/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the dual sine difference generator.
// ----------------------------------------------------------------------------
package dsd_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int NUM_CHANNELS_DEF     = 2;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int PHASE_BITS_DEF       = 32;

	// Fixed field widths
	localparam int CHAN_W     = 1;
	localparam int SAMPLE_W   = 18;
	localparam int GAIN_W     = 16;
	localparam int SINE_W     = 16;   // table magnitude, 0..32768
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_A = 2'd0,
		REG_STEP_B = 2'd1,
		REG_GAIN_A = 2'd2,
		REG_GAIN_B = 2'd3
	} cfg_reg_t;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// File: rtl/core/dsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_in_if
// Tick channel: one word names the channel whose next sample is produced.
// ----------------------------------------------------------------------------
interface dsd_in_if;
	logic                       valid;
	logic                       ready;
	logic [dsd_pkg::CHAN_W-1:0] chan;

	modport source (output valid, output chan, input ready);
	modport sink   (input valid, input chan, output ready);
endinterface

// File: rtl/core/dsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_out_if
// Sample channel: one word carries the channel and its difference sample.
// ----------------------------------------------------------------------------
interface dsd_out_if;
	logic                                valid;
	logic                                ready;
	logic [dsd_pkg::CHAN_W-1:0]          out_chan;
	logic signed [dsd_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output out_chan, output sample_out, input ready);
	modport sink   (input valid, input out_chan, input sample_out, output ready);
endinterface

// File: rtl/core/dsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/dsd_phase_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_phase_map
// Maps a phase to a quarter-wave table address and a sign.
// ----------------------------------------------------------------------------
module dsd_phase_map #(
	parameter int PHASE_BITS       = dsd_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = dsd_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic [PHASE_BITS-1:0]                 phase,
	output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
	output logic                                  neg
);

	localparam int AddrW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PosW  = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int ProdW = PHASE_BITS + PosW + 1;

	logic [ProdW-1:0] prod;
	logic [PosW-1:0]  pos;
	logic [PosW-1:0]  idx;
	logic [1:0]       quad;

	// position within the full turn, in table steps
	assign prod = ProdW'(phase) * ProdW'(4 * SINE_TABLE_DEPTH);
	assign pos  = prod[PHASE_BITS +: PosW];

	// quadrant split by compares against the quadrant bounds
	always_comb begin
		if (pos >= PosW'(3 * SINE_TABLE_DEPTH)) begin
			quad = 2'd3;
			idx  = pos - PosW'(3 * SINE_TABLE_DEPTH);
		end else if (pos >= PosW'(2 * SINE_TABLE_DEPTH)) begin
			quad = 2'd2;
			idx  = pos - PosW'(2 * SINE_TABLE_DEPTH);
		end else if (pos >= PosW'(SINE_TABLE_DEPTH)) begin
			quad = 2'd1;
			idx  = pos - PosW'(SINE_TABLE_DEPTH);
		end else begin
			quad = 2'd0;
			idx  = pos;
		end
	end

	// odd quadrants run the table backward, upper half is negative
	assign addr = quad[0] ? (AddrW'(SINE_TABLE_DEPTH) - AddrW'(idx)) : AddrW'(idx);
	assign neg  = quad[1];

endmodule

// File: rtl/core/dual_sine_difference_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sine_difference_generator_top
// Pipeline: a tick word passes the registered table read, then the output register.
// Throughput: one tick word per cycle, set by the table reads, when the output is not stalled.
// Reset: phases, steps and gains clear; the quarter-wave table then loads its
// SINE_TABLE_DEPTH+1 entries (1025 by default) with ticks held off.
// Register writes are taken at any time.
// ----------------------------------------------------------------------------
module dual_sine_difference_generator_top #(
	parameter int NUM_CHANNELS     = dsd_pkg::NUM_CHANNELS_DEF,
	parameter int SINE_TABLE_DEPTH = dsd_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_BITS       = dsd_pkg::PHASE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [dsd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dsd_pkg::CFG_DATA_W-1:0] wr_data,
	dsd_in_if.sink                         in_ch,
	dsd_out_if.source                      out_ch
);

	import dsd_pkg::*;

	localparam int RomDepth = SINE_TABLE_DEPTH + 1;
	localparam int AddrW    = $clog2(RomDepth);
	localparam int ProdW    = 2 * (SINE_W + 1);

	// table series constants; divisors of the odd terms are (2n)(2n+1)
	localparam logic [63:0] DepthQ    = 64'(SINE_TABLE_DEPTH);
	localparam logic [63:0] HalfDepth = 64'(SINE_TABLE_DEPTH / 2);
	localparam logic [63:0] TaylorDiv [1:12] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef logic [SINE_W-1:0] rom_t [RomDepth];

	// round(32768 * sin(pi/2 * k / depth)), Q30 Taylor series; elaboration only
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        scaled;
		x = (HALF_PI_Q30 * 64'(k) + HalfDepth) / DepthQ;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / TaylorDiv[n];
			if (n % 2 == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > signed'(64'd1 << 30)) begin
			sum = signed'(64'd1 << 30);
		end
		scaled = ((64'(sum) << 15) + (64'd1 << 29)) >> 30;
		return scaled[SINE_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < RomDepth; k++) begin
			r[k] = sine_entry(unsigned'(k));
		end
		return r;
	endfunction

	localparam rom_t SineRom = build_rom();

	// registers
	logic [PHASE_BITS-1:0] step_a_q;
	logic [PHASE_BITS-1:0] step_b_q;
	logic [GAIN_W-1:0]     gain_a_q;
	logic [GAIN_W-1:0]     gain_b_q;
	logic [PHASE_BITS-1:0] phase_a_q [NUM_CHANNELS];
	logic [PHASE_BITS-1:0] phase_b_q [NUM_CHANNELS];

	// table load
	logic             filling_q;
	logic [AddrW-1:0] fill_cnt_q;

	// handshake
	logic accept;
	logic out_free;
	logic chan_ok;

	// phase selection and table addressing
	logic [PHASE_BITS-1:0] ph_a;
	logic [PHASE_BITS-1:0] ph_b;
	logic [AddrW-1:0]      addr_a;
	logic [AddrW-1:0]      addr_b;
	logic                  neg_a;
	logic                  neg_b;
	logic [SINE_W-1:0]     mag_a;
	logic [SINE_W-1:0]     mag_b;

	// stage 1
	logic                valid_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic                ok_s1;
	logic                neg_a_s1;
	logic                neg_b_s1;

	// product and rounding
	logic signed [SINE_W:0]       sin_a;
	logic signed [SINE_W:0]       sin_b;
	logic signed [ProdW-1:0]      prod_a;
	logic signed [ProdW-1:0]      prod_b;
	logic signed [ProdW:0]        diff;
	logic signed [ProdW:0]        rnd;

	// output register
	logic                       out_valid_q;
	logic [CHAN_W-1:0]          out_chan_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a_q <= '0;
			step_b_q <= '0;
			gain_a_q <= '0;
			gain_b_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_STEP_A: step_a_q <= wr_data[PHASE_BITS-1:0];
				REG_STEP_B: step_b_q <= wr_data[PHASE_BITS-1:0];
				REG_GAIN_A: gain_a_q <= wr_data[GAIN_W-1:0];
				REG_GAIN_B: gain_b_q <= wr_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// table load sequencer, one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filling_q  <= 1'b1;
			fill_cnt_q <= '0;
		end else if (filling_q) begin
			fill_cnt_q <= fill_cnt_q + AddrW'(1);
			if (fill_cnt_q == AddrW'(SINE_TABLE_DEPTH)) begin
				filling_q <= 1'b0;
			end
		end
	end

	// handshake
	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !filling_q && (!valid_s1 || out_free);
	assign accept      = in_ch.valid && in_ch.ready;
	assign chan_ok     = 32'(in_ch.chan) < 32'(NUM_CHANNELS);

	// phase of the ticked channel
	always_comb begin
		ph_a = '0;
		ph_b = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (32'(in_ch.chan) == 32'(c)) begin
				ph_a = phase_a_q[c];
				ph_b = phase_b_q[c];
			end
		end
	end

	// phase accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				phase_a_q[c] <= '0;
				phase_b_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (accept && 32'(in_ch.chan) == 32'(c)) begin
					phase_a_q[c] <= phase_a_q[c] + step_a_q;
					phase_b_q[c] <= phase_b_q[c] + step_b_q;
				end
			end
		end
	end

	dsd_phase_map #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_map_a (
		.phase (ph_a),
		.addr  (addr_a),
		.neg   (neg_a)
	);

	dsd_phase_map #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_map_b (
		.phase (ph_b),
		.addr  (addr_b),
		.neg   (neg_b)
	);

	// one table copy per tone, both loaded by the same sweep
	dsd_ram #(
		.WIDTH (SINE_W),
		.DEPTH (RomDepth)
	) u_rom_a (
		.clk   (clk),
		.we    (filling_q),
		.waddr (fill_cnt_q),
		.wdata (SineRom[fill_cnt_q]),
		.re    (accept),
		.raddr (addr_a),
		.rdata (mag_a)
	);

	dsd_ram #(
		.WIDTH (SINE_W),
		.DEPTH (RomDepth)
	) u_rom_b (
		.clk   (clk),
		.we    (filling_q),
		.waddr (fill_cnt_q),
		.wdata (SineRom[fill_cnt_q]),
		.re    (accept),
		.raddr (addr_b),
		.rdata (mag_b)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_free) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 side info, moves with the table read
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1  <= in_ch.chan;
			ok_s1    <= chan_ok;
			neg_a_s1 <= neg_a;
			neg_b_s1 <= neg_b;
		end
	end

	// signed sines, scaled by gain, difference rounded half up
	assign sin_a  = neg_a_s1 ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
	assign sin_b  = neg_b_s1 ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
	assign prod_a = $signed({1'b0, gain_a_q}) * sin_a;
	assign prod_b = $signed({1'b0, gain_b_q}) * sin_b;
	assign diff   = (ProdW+1)'(prod_b) - (ProdW+1)'(prod_a);
	assign rnd    = diff + $signed((ProdW+1)'(1 << 14));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_chan_q   <= chan_s1;
			out_sample_q <= ok_s1 ? SAMPLE_W'(rnd >>> 15) : '0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_chan   = out_chan_q;
	assign out_ch.sample_out = out_sample_q;

`ifndef ASSERT_OFF
	// no tick is taken while the table loads, and the pipe stays empty
	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		filling_q |-> (!in_ch.ready && !valid_s1 && !out_valid_q))
		else $error("tick taken or pipe busy during table load");

	// an accepted tick always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted tick lost before stage 1");

	// a stalled stage 1 keeps its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(chan_s1) && $stable(mag_a)))
		else $error("stage 1 changed while stalled");

	// channel 0 phases move only on a tick for channel 0
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && in_ch.chan == '0) |=> ($stable(phase_a_q[0]) && $stable(phase_b_q[0])))
		else $error("channel 0 phase moved without a tick");
`endif

endmodule

// File: test/dsd_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_sample_checker
// Watches the register port and both word channels of the dual sine
// difference generator. Keeps its own copy of the registers, the per-channel
// phase accumulators and the quarter-wave table, predicts the difference
// sample for every accepted tick word and compares each accepted sample
// word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dsd_sample_checker #(
	parameter int NUM_CH     = dsd_pkg::NUM_CHANNELS_DEF,
	parameter int SINE_DEPTH = dsd_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_W    = dsd_pkg::PHASE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [dsd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dsd_pkg::CFG_DATA_W-1:0] wr_data,
	dsd_in_if                              in_mon,
	dsd_out_if                             out_mon,
	output int                             mismatch_count,
	output int                             samples_in_flight
);

	import dsd_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
	} sample_word_t;

	// shadow registers and phase accumulators
	logic [PHASE_W-1:0] step_a;
	logic [PHASE_W-1:0] step_b;
	logic [GAIN_W-1:0]  gain_a;
	logic [GAIN_W-1:0]  gain_b;
	logic [PHASE_W-1:0] acc_a [NUM_CH];
	logic [PHASE_W-1:0] acc_b [NUM_CH];

	int unsigned  quarter_wave [0:SINE_DEPTH];
	sample_word_t expected_samples [$];

	// one table entry: 32768 * sin(pi/2 * k / depth), Taylor series in Q30
	function automatic int unsigned quarter_wave_entry(input int unsigned k);
		longint unsigned angle;
		longint unsigned angle_sq;
		longint unsigned term;
		longint          acc;
		longint unsigned rounded;
		angle    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
		angle_sq = (angle * angle) >> 30;
		term     = angle;
		acc      = longint'(angle);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (longint'(1) << 30)) begin
			acc = longint'(1) << 30;
		end
		rounded = ((64'(acc) << 15) + (64'd1 << 29)) >> 30;
		return int'(rounded);
	endfunction

	// signed Q1.15 sine of a phase, quadrant folded onto the quarter table
	function automatic longint sine_at(input logic [PHASE_W-1:0] phase);
		longint unsigned pos;
		longint unsigned quadrant;
		longint unsigned idx;
		longint          mag;
		pos      = (64'(phase) * 64'(4 * SINE_DEPTH)) >> PHASE_W;
		quadrant = (pos / 64'(SINE_DEPTH)) % 4;
		idx      = pos % 64'(SINE_DEPTH);
		if (quadrant[0]) begin
			idx = 64'(SINE_DEPTH) - idx;
		end
		mag = longint'(quarter_wave[idx]);
		return quadrant[1] ? -mag : mag;
	endfunction

	// tone B minus tone A, Q2.15, rounded half up
	function automatic logic signed [SAMPLE_W-1:0] tone_difference(
		input logic [PHASE_W-1:0] ph_a, input logic [PHASE_W-1:0] ph_b,
		input logic [GAIN_W-1:0] g_a, input logic [GAIN_W-1:0] g_b);
		longint wa;
		longint wb;
		longint diff;
		wa   = g_a;
		wb   = g_b;
		diff = wb * sine_at(ph_b) - wa * sine_at(ph_a);
		diff = (diff + 64'sd16384) >>> 15;
		return diff[SAMPLE_W-1:0];
	endfunction

	task automatic report(input string what, input logic signed [63:0] want,
		input logic signed [63:0] got);
		$display("%0t ns: sample word mismatch on %s: expected %0d, got %0d",
			$time, what, want, got);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			quarter_wave[k] = quarter_wave_entry(k);
		end
	end

	// track registers, predict on tick words, compare on sample words
	always @(posedge clk or negedge arst_n) begin
		sample_word_t want;
		logic [CHAN_W-1:0] ch;
		if (!arst_n) begin
			step_a = '0;
			step_b = '0;
			gain_a = '0;
			gain_b = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				acc_a[c] = '0;
				acc_b[c] = '0;
			end
			expected_samples.delete();
			samples_in_flight <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_STEP_A: step_a = wr_data[PHASE_W-1:0];
					REG_STEP_B: step_b = wr_data[PHASE_W-1:0];
					REG_GAIN_A: gain_a = wr_data[GAIN_W-1:0];
					REG_GAIN_B: gain_b = wr_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				ch = in_mon.chan;
				want.chan = ch;
				if (int'(ch) < NUM_CH) begin
					want.sample = tone_difference(acc_a[ch], acc_b[ch], gain_a, gain_b);
					acc_a[ch] = acc_a[ch] + step_a;
					acc_b[ch] = acc_b[ch] + step_b;
				end else begin
					// channel beyond the configured count: silent, phases untouched
					want.sample = '0;
				end
				expected_samples.push_back(want);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_samples.size() == 0) begin
					report("unexpected word", 64'sd0, 64'(out_mon.sample_out));
				end else begin
					want = expected_samples.pop_front();
					if (out_mon.out_chan !== want.chan) begin
						report("out_chan", 64'(want.chan), 64'(out_mon.out_chan));
					end
					if (out_mon.sample_out !== want.sample) begin
						report("sample_out", 64'(want.sample), 64'(out_mon.sample_out));
					end
				end
			end
			samples_in_flight <= expected_samples.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the dual sine difference generator: a directed set of
// register settings that walks the phases over quadrant edges, full scale
// and over-unity gains, then random settings with random channel ticks.
// Both sides idle at random, the sample side holds off for a long stretch
// once, and the sample checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb;
	import dsd_pkg::*;

	localparam int IDLE_PCT        = 29;
	localparam int HOLD_CYCLES     = 300;
	localparam int NUM_SETTINGS    = 20;
	localparam int TICKS_PER_SET   = 100;
	localparam int QUIET_SET       = 5;
	localparam int HOLD_SET        = 8;
	localparam int PAUSE_SET       = 12;
	localparam int TAIL_CYCLES     = 10;
	localparam int CYCLE_LIMIT     = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int                    mismatch_count;
	int                    samples_in_flight;
	int                    cycle_count;
	bit                    quiet;
	bit                    hold_req;

	dsd_in_if  in_ch ();
	dsd_out_if out_ch ();

	dual_sine_difference_generator_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	dsd_sample_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_mon           (in_ch),
		.out_mon          (out_ch),
		.mismatch_count   (mismatch_count),
		.samples_in_flight(samples_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// sample side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// offer one tick word, wait for it to be taken, then maybe idle
	task automatic send_tick(input logic [CHAN_W-1:0] c);
		in_ch.valid <= 1'b1;
		in_ch.chan  <= c;
		do @(posedge clk); while (!in_ch.ready);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted sample has come out
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (samples_in_flight != 0);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] sa,
		input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] ga,
		input logic [CFG_DATA_W-1:0] gb);
		put_reg(REG_STEP_A, sa);
		put_reg(REG_STEP_B, sb);
		put_reg(REG_GAIN_A, ga);
		put_reg(REG_GAIN_B, gb);
		wr_en <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_step();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(31);
			3: return 32'($urandom_range(3)) << 30;
			4: return 32'($urandom_range(32'h000f_ffff));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return 32'd32768;
			2: return 32'd65535;
			3: return $urandom();   // upper bits dropped, often above unity
			default: return 32'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		arst_n      <= 1'b0;
		wr_en       <= 1'b0;
		wr_index    <= REG_STEP_A;
		wr_data     <= '0;
		in_ch.valid <= 1'b0;
		in_ch.chan  <= '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: both tones silent
		send_tick(1'b0);
		send_tick(1'b1);
		drain();

		// quarter and half turn steps land on quadrant edges; tone B above unity
		load_settings(32'h4000_0000, 32'h8000_0000, 32'd32768, 32'd65535);
		repeat (6) send_tick(1'b0);
		repeat (2) send_tick(1'b1);
		drain();

		// maximum step wraps the accumulator; gain written with all bits set
		load_settings(32'hffff_ffff, 32'h0010_0000, 32'hffff_ffff, 32'd0);
		repeat (4) send_tick(1'b1);
		send_tick(1'b0);
		drain();

		// equal full-scale gains, channels interleaved
		load_settings(32'h2000_0000, 32'h6000_0000, 32'd32768, 32'd32768);
		repeat (4) begin
			send_tick(1'b0);
			send_tick(1'b1);
		end
		drain();

		// frozen tone A, smallest nonzero gain on tone B
		load_settings(32'd0, 32'hc000_0000, 32'd0, 32'd1);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();

		// random settings, each followed by a run of random ticks
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			load_settings(pick_step(), pick_step(), pick_gain(), pick_gain());
			quiet = (s == QUIET_SET);
			if (s == HOLD_SET) begin
				hold_req = 1'b1;
			end
			for (int t = 0; t < TICKS_PER_SET; t++) begin
				if (s == PAUSE_SET && t == TICKS_PER_SET / 2) begin
					drain();
				end
				send_tick(CHAN_W'($urandom_range(1)));
			end
			drain();
		end
		quiet = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
